/* rtl/pmfa_pkg.sv */
// ============================================================================
// pmfa_pkg - shared types and constants for the paged MMU frame allocator
// Holds the request and response payloads, the entry layout, the status and
// function codes, and the sizes of the page table and frame map.
// ============================================================================
`timescale 1ns / 1ps

package pmfa_pkg;

  // Page table geometry. The space index is used directly, so SPACES is a
  // power of two.
  localparam int SPACES          = 8;
  localparam int PAGES_PER_SPACE = 32;
  localparam int SPACE_W         = $clog2(SPACES);
  localparam int PAGE_W          = $clog2(PAGES_PER_SPACE);
  localparam int IDX_W           = SPACE_W + PAGE_W;
  localparam int ENTRIES         = SPACES * PAGES_PER_SPACE;

  // Physical side: 32 frames of 2048 words.
  localparam int FRAMES   = 32;
  localparam int FRAME_W  = 5;
  localparam int OFFSET_W = 11;
  localparam int ADDR_W   = 16;
  localparam int ENT_W    = 8;

  localparam logic [FRAMES-1:0]  FRAME_MAP_RESET = 32'hFFFF_FFF8;
  localparam logic [FRAME_W-1:0] LAST_FRAME      = 5'd31;
  localparam logic [PAGE_W-1:0]  LIMIT_RESET     = 5'd5;

  // Entry bit positions: frame in [7:3], write, read, valid.
  localparam int ENT_VALID = 0;
  localparam int ENT_READ  = 1;
  localparam int ENT_WRITE = 2;

  // Function codes.
  localparam logic [1:0] FN_READ  = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_ALLOC = 2'd2;
  localparam logic [1:0] FN_FREE  = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ALREADY   = 3'd1;
  localparam logic [2:0] ST_NO_FRAME  = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [2:0] ST_RESERVED  = 3'd4;
  localparam logic [2:0] ST_UNMAPPED  = 3'd5;
  localparam logic [2:0] ST_NO_READ   = 3'd6;
  localparam logic [2:0] ST_NO_WRITE  = 3'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         space;
    logic [ADDR_W-1:0]  address;
    logic [PAGE_W-1:0]  page;
    logic               can_read;
    logic               can_write;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ADDR_W-1:0]  phys_address;
    logic [FRAME_W-1:0] frame;
    logic               frames_full;
  } rsp_t;

  // State update produced by one request.
  typedef struct packed {
    logic [FRAMES-1:0] map_nxt;
    logic              full_nxt;
    logic              ent_we;
    logic [ENT_W-1:0]  ent_data;
  } upd_t;

endpackage

/* rtl/paged_mmu_frame_allocator.sv */
// ============================================================================
// paged_mmu_frame_allocator - page-table MMU with a physical frame allocator
// Translates, allocates and frees pages of several address spaces against
// one bitmap of 32 physical frames.
// ============================================================================
// Stages: an accepted request enters the working stage register while the
//   page table RAM read is registered; the output register holds the response.
// Throughput: one request per cycle unless the output stalls; page entry, frame
//   map and full flag are read and updated in one pass, last write forwarded.
// Reset: frames 0 to 2 in use, all page entries invalid (per-entry written
//   bits, no clearing pass), full flag clear, reserved page limit 5.
`timescale 1ns / 1ps

module paged_mmu_frame_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pmfa_pkg::req_t                in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pmfa_pkg::rsp_t                out_rsp,
  input  logic                          cfg_we,
  input  logic [pmfa_pkg::PAGE_W-1:0]   cfg_data
);

  logic                               s1_vld_r;
  pmfa_pkg::req_t                     s1_req_r;
  logic [pmfa_pkg::IDX_W-1:0]         s1_idx_r;
  logic                               s1_adv;
  logic                               in_acc;
  logic [pmfa_pkg::IDX_W-1:0]         in_idx;

  logic                               out_vld_r;
  pmfa_pkg::rsp_t                     out_rsp_r;

  logic [pmfa_pkg::FRAMES-1:0]        map_r;
  logic                               full_r;
  logic [pmfa_pkg::PAGE_W-1:0]        limit_r;
  logic [pmfa_pkg::ENTRIES-1:0]       written_r;

  logic                               fwd_vld_r;
  logic [pmfa_pkg::IDX_W-1:0]         fwd_idx_r;
  logic [pmfa_pkg::ENT_W-1:0]         fwd_data_r;

  logic [pmfa_pkg::ENT_W-1:0]         ram_rdata;
  logic [pmfa_pkg::ENT_W-1:0]         entry;
  pmfa_pkg::rsp_t                     rsp;
  pmfa_pkg::upd_t                     upd;

  // Handshake: the working stage moves on whenever the output register
  // is free or being emptied.
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || s1_adv;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

  // Entry index: translate uses the page from the address.
  always_comb begin
    if (in_req.func == pmfa_pkg::FN_READ || in_req.func == pmfa_pkg::FN_WRITE) begin
      in_idx = {in_req.space[pmfa_pkg::SPACE_W-1:0],
                in_req.address[pmfa_pkg::ADDR_W-1 -: pmfa_pkg::PAGE_W]};
    end else begin
      in_idx = {in_req.space[pmfa_pkg::SPACE_W-1:0], in_req.page};
    end
  end

  // Page table storage.
  pmfa_ram #(
    .WIDTH (pmfa_pkg::ENT_W),
    .DEPTH (pmfa_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (s1_adv && upd.ent_we),
    .waddr (s1_idx_r),
    .wdata (upd.ent_data),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // Entry as seen by the working stage: the last write wins over the RAM,
  // and a never-written entry reads as zero.
  always_comb begin
    if (!written_r[s1_idx_r]) begin
      entry = '0;
    end else if (fwd_vld_r && fwd_idx_r == s1_idx_r) begin
      entry = fwd_data_r;
    end else begin
      entry = ram_rdata;
    end
  end

  pmfa_exec u_exec (
    .req       (s1_req_r),
    .entry     (entry),
    .frame_map (map_r),
    .full      (full_r),
    .limit     (limit_r),
    .rsp       (rsp),
    .upd       (upd)
  );

  // Working stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
    if (in_acc) begin
      s1_req_r <= in_req;
      s1_idx_r <= in_idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (s1_adv) begin
      out_rsp_r <= rsp;
    end
  end

  // Allocator state, written bits and the entry forwarding register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r     <= pmfa_pkg::FRAME_MAP_RESET;
      full_r    <= 1'b0;
      written_r <= '0;
      fwd_vld_r <= 1'b0;
    end else if (s1_adv) begin
      map_r  <= upd.map_nxt;
      full_r <= upd.full_nxt;
      if (upd.ent_we) begin
        written_r[s1_idx_r] <= 1'b1;
        fwd_vld_r           <= 1'b1;
      end
    end
    if (s1_adv && upd.ent_we) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= upd.ent_data;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= pmfa_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  // The full flag is only set by taking the last frame, and any free clears it.
  a_full_last_taken: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> !map_r[pmfa_pkg::FRAMES-1])
    else $error("full flag set while the last frame is free");

  // Frames held since reset are never handed back.
  a_low_frames_held: assert property (@(posedge clk) disable iff (!rst_n)
    map_r[2:0] == 3'b000)
    else $error("a frame reserved at reset became free");

  // Input stalls only when the working stage is blocked by a full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a blocked output");

  // A response appears in the cycle after the working stage moves on.
  a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("advanced request produced no response");

endmodule

/* rtl/pmfa_ram.sv */
// ============================================================================
// pmfa_ram - generic single-port-write RAM with a registered read
// One write port and one read port; a read at the address being written
// returns the old contents.
// ============================================================================
`timescale 1ns / 1ps

module pmfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pmfa_exec.sv */
// ============================================================================
// pmfa_exec - request evaluation for the paged MMU frame allocator
// Checks one request against its page entry, the frame map and the full
// flag, and produces the response and the state update.
// ============================================================================
`timescale 1ns / 1ps

module pmfa_exec (
  input  pmfa_pkg::req_t                     req,
  input  logic [pmfa_pkg::ENT_W-1:0]         entry,
  input  logic [pmfa_pkg::FRAMES-1:0]        frame_map,
  input  logic                               full,
  input  logic [pmfa_pkg::PAGE_W-1:0]        limit,
  output pmfa_pkg::rsp_t                     rsp,
  output pmfa_pkg::upd_t                     upd
);

  logic [pmfa_pkg::PAGE_W-1:0]   vpn;
  logic [pmfa_pkg::FRAME_W-1:0]  ent_frame;
  logic [pmfa_pkg::FRAME_W-1:0]  low_free;
  logic [pmfa_pkg::FRAMES-1:0]   low_onehot;
  logic [pmfa_pkg::FRAMES-1:0]   ent_onehot;

  assign vpn        = req.address[pmfa_pkg::ADDR_W-1 -: pmfa_pkg::PAGE_W];
  assign ent_frame  = entry[pmfa_pkg::ENT_W-1 -: pmfa_pkg::FRAME_W];
  assign low_onehot = pmfa_pkg::FRAMES'(1) << low_free;
  assign ent_onehot = pmfa_pkg::FRAMES'(1) << ent_frame;

  // Lowest free frame; scanning from the top leaves the lowest set bit.
  always_comb begin
    low_free = '0;
    for (int i = pmfa_pkg::FRAMES - 1; i >= 0; i--) begin
      if (frame_map[i]) begin
        low_free = pmfa_pkg::FRAME_W'(i);
      end
    end
  end

  // Per-function checks and updates.
  always_comb begin
    rsp.status       = pmfa_pkg::ST_OK;
    rsp.phys_address = '0;
    rsp.frame        = '0;
    upd.map_nxt      = frame_map;
    upd.full_nxt     = full;
    upd.ent_we       = 1'b0;
    upd.ent_data     = entry;
    case (req.func)
      pmfa_pkg::FN_ALLOC: begin
        if (entry[pmfa_pkg::ENT_VALID]) begin
          rsp.status = pmfa_pkg::ST_ALREADY;
        end else if (frame_map == '0) begin
          rsp.status = pmfa_pkg::ST_NO_FRAME;
        end else begin
          // A request with no permission still takes a frame but the
          // entry stays invalid.
          upd.map_nxt  = frame_map & ~low_onehot;
          upd.ent_we   = 1'b1;
          upd.ent_data = {low_free, req.can_write, req.can_read,
                          req.can_read | req.can_write};
          upd.full_nxt = full | (low_free == pmfa_pkg::LAST_FRAME);
          rsp.frame    = low_free;
        end
      end
      pmfa_pkg::FN_FREE: begin
        if (!entry[pmfa_pkg::ENT_VALID]) begin
          rsp.status = pmfa_pkg::ST_NOT_ALLOC;
        end else begin
          upd.map_nxt  = frame_map | ent_onehot;
          upd.ent_we   = 1'b1;
          upd.ent_data = {entry[pmfa_pkg::ENT_W-1:1], 1'b0};
          upd.full_nxt = 1'b0;
          rsp.frame    = ent_frame;
        end
      end
      default: begin
        // Read or write translate.
        if (vpn <= limit) begin
          rsp.status = pmfa_pkg::ST_RESERVED;
        end else if (!entry[pmfa_pkg::ENT_VALID]) begin
          rsp.status = pmfa_pkg::ST_UNMAPPED;
        end else if (req.func == pmfa_pkg::FN_READ && !entry[pmfa_pkg::ENT_READ]) begin
          rsp.status = pmfa_pkg::ST_NO_READ;
        end else if (req.func == pmfa_pkg::FN_WRITE && !entry[pmfa_pkg::ENT_WRITE]) begin
          rsp.status = pmfa_pkg::ST_NO_WRITE;
        end else begin
          rsp.phys_address = {ent_frame, req.address[pmfa_pkg::OFFSET_W-1:0]};
        end
      end
    endcase
    rsp.frames_full = upd.full_nxt;
  end

endmodule
